// ===== sv/ttpd_pkg.sv =====
package ttpd_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_HEADER = 2'd1,
		CMD_DATA   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_HEADER  = 2'd1,
		ST_BAD_POINTER = 2'd2
	} status_t;

	typedef enum logic {
		KIND_SYMBOL = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BIT,
		S_PTR,
		S_LEAFTEST,
		S_LEAF,
		S_FLUSH
	} state_t;

	// word index (paddr[2]) of the register
	localparam logic REG_MAX_SYMBOLS = 1'b0;

	localparam logic [31:0] DATA_MAX      = 32'h0000_00ff;
	localparam logic [7:0]  HEADER_OK     = 8'd1;
	localparam logic [3:0]  BITS_MAX      = 4'd8;
	localparam logic [15:0] MAX_SYM_RESET = 16'hffff;

endpackage

// ===== sv/table_tree_prefix_decoder.sv =====
// Prefix-code decoder that walks a code tree held in a table of 32-bit words.
// Input channel (in_valid/in_ready) takes one command word: a table write,
// a frame header, or a data byte of 0..8 code bits, least significant first.
// Output channel (out_valid/out_ready) gives decoded symbols (kind 0) and
// frame status (kind 1); last marks the final result caused by one word.
// max_symbols sits at APB byte address 0; pready is always high.
// Each bit needs up to three dependent reads of the node table (child pointer,
// the target's entries 0 and 1 on the two read ports, then the leaf's entry 3),
// each through a registered read port. A new word is taken only once the
// previous one has finished and handed its results on.
// Results are held one deep in a pending register until the next result or
// the end of the word decides last; the output register then carries them.
// When the receiver stalls, the walk holds in place until a slot frees up.
// Reset closes any frame, returns the walk to the root, clears the symbol
// count and root base and sets max_symbols to 65535; the table itself is
// not cleared and holds garbage until loaded.
module table_tree_prefix_decoder #(
	parameter int TABLE_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [10:0] table_index,
	input  logic [31:0] table_word,
	input  logic [7:0]  header_byte,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  bit_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  symbol,
	output logic [1:0]  status,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int AW1 = AW + 1;
	localparam logic [31:0]  DEPTH_M1 = 32'(TABLE_DEPTH - 1);
	localparam logic [AW:0]  DEPTH_W  = AW1'(TABLE_DEPTH);
	localparam logic [AW-1:0] ROOT    = AW'(1);

	ttpd_pkg::state_t state_q, state_d;

	logic [31:0]   mem [0:TABLE_DEPTH-1];
	logic [31:0]   rd_a_q, rd_b_q;
	logic          rd_en;
	logic [AW-1:0] rd_a_addr, rd_b_addr;
	logic          wr_en;

	logic [31:0]   root_q;
	logic [15:0]   max_q;
	logic [15:0]   count_q;
	logic          active_q;
	logic [AW-1:0] node_q;
	logic [3:0]    bit_q, nbits_q;
	logic [7:0]    data_q;

	logic          pend_valid_q;
	logic          pend_kind_q;
	logic [7:0]    pend_symbol_q;
	logic [1:0]    pend_status_q;

	logic          out_valid_q, kind_q, last_q;
	logic [7:0]    symbol_q;
	logic [1:0]    status_q;

	logic          accept, out_free, stall;
	logic          bit_go, cur_bit, ptr_bad, is_leaf, leaf_bad;
	logic [31:0]   tgt32;

	logic          emit, push_last, bit_adv, node_tgt, node_root, count_inc, close_frame;
	logic          new_kind;
	logic [7:0]    new_symbol;
	logic [1:0]    new_status;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == ttpd_pkg::REG_MAX_SYMBOLS) ? {16'b0, max_q} : '0;
	assign in_ready = (state_q == ttpd_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign stall    = pend_valid_q && !out_free;

	assign bit_go   = (bit_q < nbits_q) && (count_q < max_q);
	assign cur_bit  = data_q[bit_q[2:0]];
	assign tgt32    = ((rd_a_q - root_q) >> 2) + 32'd1;
	assign ptr_bad  = (rd_a_q <= ttpd_pkg::DATA_MAX) || (tgt32 >= DEPTH_M1);
	assign is_leaf  = (rd_a_q == '0) && (rd_b_q == '0);
	assign leaf_bad = (AW1'(node_q) + AW1'(3)) >= DEPTH_W;

	assign wr_en = accept && (cmd == ttpd_pkg::CMD_WRITE)
		&& (32'(table_index) < 32'(TABLE_DEPTH));

	// Node table: one write port, two registered read ports. Writes come only
	// from idle, reads only during a walk, so the two never meet.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(table_index)] <= table_word;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_a_addr];
			rd_b_q <= mem[rd_b_addr];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttpd_pkg::S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						ttpd_pkg::CMD_HEADER: state_d = ttpd_pkg::S_FLUSH;
						ttpd_pkg::CMD_DATA:   state_d = active_q ? ttpd_pkg::S_BIT
							: ttpd_pkg::S_IDLE;
						default:              state_d = ttpd_pkg::S_IDLE;
					endcase
				end
			end
			ttpd_pkg::S_BIT: begin
				state_d = bit_go ? ttpd_pkg::S_PTR : ttpd_pkg::S_FLUSH;
			end
			ttpd_pkg::S_PTR: begin
				if (!ptr_bad) begin
					state_d = ttpd_pkg::S_LEAFTEST;
				end else if (!stall) begin
					state_d = ttpd_pkg::S_FLUSH;
				end
			end
			ttpd_pkg::S_LEAFTEST: begin
				if (!is_leaf) begin
					state_d = ttpd_pkg::S_BIT;
				end else if (!leaf_bad) begin
					state_d = ttpd_pkg::S_LEAF;
				end else if (!stall) begin
					state_d = ttpd_pkg::S_FLUSH;
				end
			end
			ttpd_pkg::S_LEAF: begin
				if (!stall) begin
					state_d = ttpd_pkg::S_BIT;
				end
			end
			ttpd_pkg::S_FLUSH: begin
				if (!stall) begin
					state_d = ttpd_pkg::S_IDLE;
				end
			end
			default: state_d = ttpd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		rd_en       = 1'b0;
		rd_a_addr   = node_q;
		rd_b_addr   = node_q;
		emit        = 1'b0;
		push_last   = 1'b0;
		bit_adv     = 1'b0;
		node_tgt    = 1'b0;
		node_root   = 1'b0;
		count_inc   = 1'b0;
		close_frame = 1'b0;
		new_kind    = ttpd_pkg::KIND_STATUS;
		new_symbol  = '0;
		new_status  = ttpd_pkg::ST_OK;
		unique case (state_q)
			ttpd_pkg::S_IDLE: begin
				if (accept && (cmd == ttpd_pkg::CMD_HEADER)) begin
					emit       = 1'b1;
					new_status = (header_byte == ttpd_pkg::HEADER_OK) ? ttpd_pkg::ST_OK
						: ttpd_pkg::ST_BAD_HEADER;
				end
			end
			ttpd_pkg::S_BIT: begin
				rd_en     = bit_go;
				rd_a_addr = node_q + AW'(cur_bit);
			end
			ttpd_pkg::S_PTR: begin
				if (ptr_bad) begin
					emit        = !stall;
					close_frame = !stall;
					new_status  = ttpd_pkg::ST_BAD_POINTER;
				end else begin
					// fetch entries 0 and 1 of the target together
					rd_en     = 1'b1;
					rd_a_addr = tgt32[AW-1:0];
					rd_b_addr = tgt32[AW-1:0] + AW'(1);
					node_tgt  = 1'b1;
				end
			end
			ttpd_pkg::S_LEAFTEST: begin
				if (!is_leaf) begin
					bit_adv = 1'b1;
				end else if (leaf_bad) begin
					emit        = !stall;
					close_frame = !stall;
					new_status  = ttpd_pkg::ST_BAD_POINTER;
				end else begin
					rd_en     = 1'b1;
					rd_a_addr = node_q + AW'(3);
				end
			end
			ttpd_pkg::S_LEAF: begin
				emit       = !stall;
				count_inc  = !stall;
				node_root  = !stall;
				bit_adv    = !stall;
				new_kind   = ttpd_pkg::KIND_SYMBOL;
				new_symbol = rd_a_q[7:0];
			end
			ttpd_pkg::S_FLUSH: begin
				push_last = pend_valid_q && out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ttpd_pkg::S_IDLE;
			root_q       <= '0;
			max_q        <= ttpd_pkg::MAX_SYM_RESET;
			count_q      <= '0;
			active_q     <= 1'b0;
			node_q       <= ROOT;
			bit_q        <= '0;
			nbits_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (psel && penable && pwrite && pready
				&& (paddr[2] == ttpd_pkg::REG_MAX_SYMBOLS)) begin
				max_q <= pwdata[15:0];
			end

			if (wr_en && (table_index == '0)) begin
				root_q <= table_word;
			end

			if (accept && (cmd == ttpd_pkg::CMD_HEADER)) begin
				active_q <= (header_byte == ttpd_pkg::HEADER_OK);
				if (header_byte == ttpd_pkg::HEADER_OK) begin
					node_q  <= ROOT;
					count_q <= '0;
				end
			end
			if (accept && (cmd == ttpd_pkg::CMD_DATA)) begin
				bit_q   <= '0;
				nbits_q <= (bit_count > ttpd_pkg::BITS_MAX) ? ttpd_pkg::BITS_MAX : bit_count;
			end

			if (close_frame) begin
				active_q <= 1'b0;
			end
			if (node_tgt) begin
				node_q <= tgt32[AW-1:0];
			end else if (node_root) begin
				node_q <= ROOT;
			end
			if (count_inc) begin
				count_q <= count_q + 16'd1;
			end
			if (bit_adv) begin
				bit_q <= bit_q + 4'd1;
			end

			// pending result moves on once the next one arrives, or at the end
			if (emit) begin
				pend_valid_q <= 1'b1;
			end else if (push_last) begin
				pend_valid_q <= 1'b0;
			end
			if ((emit && pend_valid_q) || push_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == ttpd_pkg::CMD_DATA)) begin
			data_q <= data_byte;
		end
		if (emit) begin
			pend_kind_q   <= new_kind;
			pend_symbol_q <= new_symbol;
			pend_status_q <= new_status;
		end
		if ((emit && pend_valid_q) || push_last) begin
			kind_q   <= pend_kind_q;
			symbol_q <= pend_symbol_q;
			status_q <= pend_status_q;
			last_q   <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign symbol    = symbol_q;
	assign status    = status_q;
	assign last      = last_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttpd_pkg::S_IDLE) |-> !pend_valid_q)
		else $error("pending result left over at idle");

	a_leaf_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttpd_pkg::S_LEAF) |-> active_q)
		else $error("symbol emitted outside a frame");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && pend_valid_q) |-> out_free)
		else $error("result pushed into a full output register");

	a_walk_from_frame: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ttpd_pkg::S_IDLE) && (state_d == ttpd_pkg::S_BIT)) |-> active_q)
		else $error("walk started with no open frame");

endmodule

// ===== tb/ttpd_decode_checker.sv =====
module ttpd_decode_checker #(
	parameter int TABLE_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [10:0] table_index,
	input  logic [31:0] table_word,
	input  logic [7:0]  header_byte,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  bit_count,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        kind,
	input  logic [7:0]  symbol,
	input  logic [1:0]  status,
	input  logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		ttpd_pkg::kind_t   kind;
		logic [7:0]        symbol;
		ttpd_pkg::status_t status;
		logic              last;
	} result_t;

	result_t     results_due[$];
	logic [31:0] tree_mem [TABLE_DEPTH];
	logic [31:0] base_word;
	logic [31:0] walk_node;
	logic        in_frame;
	int unsigned emitted;
	logic [15:0] symbol_limit;
	int          fail_count;

	function automatic logic [31:0] entry_at(input logic [31:0] idx);
		return (idx < TABLE_DEPTH) ? tree_mem[idx] : 32'd0;
	endfunction

	function automatic result_t status_result(input ttpd_pkg::status_t code);
		result_t r;
		r.kind   = ttpd_pkg::KIND_STATUS;
		r.symbol = 8'd0;
		r.status = code;
		r.last   = 1'b0;
		return r;
	endfunction

	task automatic decode_word(input ttpd_pkg::cmd_t c, input logic [10:0] idx,
			input logic [31:0] w, input logic [7:0] hdr, input logic [7:0] bits,
			input logic [3:0] cnt);
		result_t     made[$];
		result_t     r;
		logic [31:0] entry;
		logic [31:0] target;
		int unsigned nbits;
		nbits = 32'((cnt > ttpd_pkg::BITS_MAX) ? ttpd_pkg::BITS_MAX : cnt);
		case (c)
		ttpd_pkg::CMD_WRITE: begin
			if (idx < TABLE_DEPTH) begin
				tree_mem[idx] = w;
				if (idx == 0)
					base_word = w;
			end
		end
		ttpd_pkg::CMD_HEADER: begin
			if (hdr == ttpd_pkg::HEADER_OK) begin
				in_frame = 1'b1;
				walk_node = 32'd1;
				emitted = 0;
				made.push_back(status_result(ttpd_pkg::ST_OK));
			end else begin
				in_frame = 1'b0;
				made.push_back(status_result(ttpd_pkg::ST_BAD_HEADER));
			end
		end
		ttpd_pkg::CMD_DATA: begin
			if (in_frame) begin
				for (int i = 0; i < nbits; i++) begin
					if (emitted >= symbol_limit)
						break;
					entry = entry_at(walk_node + bits[i]);
					target = ((entry - base_word) >> 2) + 32'd1;
					if (entry <= ttpd_pkg::DATA_MAX || target >= TABLE_DEPTH
							|| target + 1 >= TABLE_DEPTH) begin
						made.push_back(status_result(ttpd_pkg::ST_BAD_POINTER));
						in_frame = 1'b0;
						break;
					end
					walk_node = target;
					if (entry_at(target) == 0 && entry_at(target + 1) == 0) begin
						// leaf data word sits at offset three
						if (target + 3 >= TABLE_DEPTH) begin
							made.push_back(status_result(ttpd_pkg::ST_BAD_POINTER));
							in_frame = 1'b0;
							break;
						end
						entry = entry_at(target + 3);
						r.kind   = ttpd_pkg::KIND_SYMBOL;
						r.symbol = entry[7:0];
						r.status = ttpd_pkg::ST_OK;
						r.last   = 1'b0;
						made.push_back(r);
						emitted++;
						walk_node = 32'd1;
					end
				end
			end
		end
		default: ;
		endcase
		if (made.size() > 0)
			made[made.size() - 1].last = 1'b1;
		foreach (made[k])
			results_due.push_back(made[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			results_due.delete();
			base_word = 32'd0;
			walk_node = 32'd1;
			in_frame = 1'b0;
			emitted = 0;
			symbol_limit = ttpd_pkg::MAX_SYM_RESET;
			fail_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// retire the result first: a word may be taken as the previous one drains
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: kind %0d symbol %02h status %0d last %0d",
							kind, symbol, status, last);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					if (kind !== want.kind || symbol !== want.symbol ||
							status !== want.status || last !== want.last) begin
						if (fail_count < 10)
							$display({"result mismatch: expected kind %0d symbol %02h status %0d ",
								"last %0d, got kind %0d symbol %02h status %0d last %0d"},
								want.kind, want.symbol, want.status, want.last,
								kind, symbol, status, last);
						fail_count++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr[2] == ttpd_pkg::REG_MAX_SYMBOLS)
				symbol_limit = pwdata[15:0];
			if (in_valid && in_ready)
				decode_word(ttpd_pkg::cmd_t'(cmd), table_index, table_word, header_byte,
					data_byte, bit_count);
			outstanding <= results_due.size();
			mismatches <= fail_count;
		end
	end

endmodule

// ===== tb/table_tree_prefix_decoder_tb.sv =====
module table_tree_prefix_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH    = 2048;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 48;

	typedef struct {
		ttpd_pkg::cmd_t cmd;
		logic [10:0]    index;
		logic [31:0]    word;
		logic [7:0]     header;
		logic [7:0]     data;
		logic [3:0]     count;
	} in_word_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic [1:0]  cmd         = '0;
	logic [10:0] table_index = '0;
	logic [31:0] table_word  = '0;
	logic [7:0]  header_byte = '0;
	logic [7:0]  data_byte   = '0;
	logic [3:0]  bit_count   = '0;
	logic        out_ready   = 1'b0;
	logic        psel        = 1'b0;
	logic        penable     = 1'b0;
	logic        pwrite      = 1'b0;
	logic [2:0]  paddr       = '0;
	logic [31:0] pwdata      = '0;
	logic        in_ready;
	logic        out_valid;
	logic        kind;
	logic [7:0]  symbol;
	logic [1:0]  status;
	logic        last;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          outstanding;
	int          send_idle  = 0;
	int          stall_pct  = 0;
	int          words_sent = 0;
	int          quiet      = 0;
	logic [31:0] tree_base  = '0;

	table_tree_prefix_decoder #(.TABLE_DEPTH(TABLE_DEPTH)) dut (.*);

	ttpd_decode_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

	always #2 clk = ~clk;

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic in_word_t noise_word();
		in_word_t w;
		w.cmd    = ttpd_pkg::cmd_t'(2'($urandom_range(3)));
		w.index  = 11'($urandom);
		w.word   = $urandom;
		w.header = 8'($urandom);
		w.data   = 8'($urandom);
		w.count  = 4'($urandom);
		return w;
	endfunction

	function automatic logic [31:0] ptr_to(input int unsigned node);
		return tree_base + ((node - 1) << 2);
	endfunction

	function automatic logic [3:0] bit_span();
		return ($urandom_range(99) < 85) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(15));
	endfunction

	task automatic push_word(input in_word_t w);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= w.cmd;
		table_index <= w.index;
		table_word  <= w.word;
		header_byte <= w.header;
		data_byte   <= w.data;
		bit_count   <= w.count;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		if (w.cmd == ttpd_pkg::CMD_WRITE && w.index == 0)
			tree_base = w.word;
	endtask

	task automatic load(input logic [10:0] idx, input logic [31:0] val);
		in_word_t w;
		w = noise_word();
		w.cmd = ttpd_pkg::CMD_WRITE;
		w.index = idx;
		w.word = val;
		push_word(w);
	endtask

	task automatic open_frame(input logic [7:0] hdr);
		in_word_t w;
		w = noise_word();
		w.cmd = ttpd_pkg::CMD_HEADER;
		w.header = hdr;
		push_word(w);
	endtask

	task automatic feed(input logic [7:0] bits, input logic [3:0] n);
		in_word_t w;
		w = noise_word();
		w.cmd = ttpd_pkg::CMD_DATA;
		w.data = bits;
		w.count = n;
		push_word(w);
	endtask

	// hold off until every result is in, then give a word with no results time to finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {ttpd_pkg::REG_MAX_SYMBOLS, 2'b00};
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// grow a random full tree under the root; leaves get zero links and a data word
	task automatic build_tree(input int unsigned inner_max);
		int unsigned slots[$];
		int unsigned node;
		int unsigned inner;
		int unsigned slot;
		if ($urandom_range(1))
			load(0, $urandom);
		node = $urandom_range(80, 1960);
		inner = 0;
		slots.push_back(1);
		slots.push_back(2);
		while (slots.size() > 0) begin
			slot = slots.pop_front();
			if (inner < inner_max && $urandom_range(2) != 0) begin
				inner++;
				slots.push_back(node);
				slots.push_back(node + 1);
			end else begin
				load(11'(node), 32'd0);
				load(11'(node + 1), 32'd0);
				load(11'(node + 3), $urandom_range(1) ? $urandom_range(255) : $urandom);
			end
			load(11'(slot), ptr_to(node) + $urandom_range(3));
			node += 4;
		end
	endtask

	initial begin
		int          phase_end;
		int unsigned pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the table powers up as garbage: clear every entry the walk could reach
		for (int i = 0; i < TABLE_DEPTH; i++)
			load(11'(i), 32'd0);

		feed(8'h5a, 4'd8);
		push_word('{ttpd_pkg::CMD_NONE, 11'h7ff, 32'hffff_ffff, 8'hff, 8'hff, 4'hf});
		open_frame(8'h00);
		open_frame(8'hff);
		open_frame(ttpd_pkg::HEADER_OK);
		feed(8'h01, 4'd1);

		load(0, 32'h8000_0000);
		load(1, ptr_to(100));
		load(2, ptr_to(104));
		load(103, 32'h1234_56a5);
		load(107, 32'h0000_003c);
		open_frame(ttpd_pkg::HEADER_OK);
		feed(8'hff, 4'd8);
		feed(8'h00, 4'd0);
		feed(8'h96, 4'd15);
		// shift the base under a live frame: the left link now lands one entry early
		load(0, 32'h8000_0004);
		feed(8'h00, 4'd1);
		load(0, 32'h8000_0000);

		load(2, ptr_to(2047));
		open_frame(ttpd_pkg::HEADER_OK);
		feed(8'h02, 4'd2);
		load(2, ptr_to(2046));
		open_frame(ttpd_pkg::HEADER_OK);
		feed(8'h02, 4'd2);
		load(2, ttpd_pkg::DATA_MAX);
		open_frame(ttpd_pkg::HEADER_OK);
		feed(8'h02, 4'd2);
		load(2, ptr_to(104));

		write_limit(16'd3);
		open_frame(ttpd_pkg::HEADER_OK);
		feed(8'h00, 4'd8);
		feed(8'hff, 4'd8);
		write_limit(16'd0);
		open_frame(ttpd_pkg::HEADER_OK);
		feed(8'hff, 4'd8);

		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin
				write_limit(ttpd_pkg::MAX_SYM_RESET);
				send_idle = 0;
				stall_pct = 0;
			end
			1: begin
				write_limit(16'($urandom_range(3, 10)));
				send_idle = 60;
				stall_pct = 0;
			end
			2: begin
				write_limit(ttpd_pkg::MAX_SYM_RESET);
				send_idle = 0;
				stall_pct = 60;
			end
			default: begin
				write_limit(16'($urandom_range(1, 3)));
				send_idle = 23;
				stall_pct = 23;
			end
			endcase
			build_tree($urandom_range(1, 7));
			phase_end = words_sent + 58;
			while (words_sent < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 62) begin
					open_frame(ttpd_pkg::HEADER_OK);
					repeat ($urandom_range(1, 5))
						feed(8'($urandom), bit_span());
				end else if (pick < 68) begin
					open_frame(8'($urandom));
				end else if (pick < 74) begin
					feed(8'($urandom), bit_span());
				end else if (pick < 80) begin
					push_word(noise_word());
				end else if (pick < 86) begin
					// break a root link
					load(11'($urandom_range(1, 2)),
						$urandom_range(1) ? $urandom_range(255) : $urandom);
				end else if (pick < 94) begin
					build_tree($urandom_range(1, 7));
				end else begin
					wait_idle();
				end
			end
		end

		wait_idle();
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
